FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// condition implies consequence in the next cycle
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/crchpt_pkg.sv
// shared constants, types and the crc byte step for the hashed table
`timescale 1ns / 1ps
package crchpt_pkg;

  localparam int TABLE_SIZE  = 1024;
  localparam int MAX_KEY_LEN = 16;
  localparam int IDX_W       = $clog2(TABLE_SIZE);
  localparam int KEY_IDX_W   = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int LEN_W       = $clog2(MAX_KEY_LEN + 1);
  localparam int SLOT_W      = 10;
  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;

  // commands from controller to datapath
  typedef struct packed {
    logic clear;
    logic take;
    logic rd;
    logic next;
    logic finish;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clear_done;
    logic empty;
    logic match;
    logic wrap_end;
  } sts_t;

  // reflected crc-32 over one byte
  function automatic logic [31:0] crc_feed(input logic [31:0] r, input logic [7:0] b);
    logic [31:0] c;
    c = r ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/crchpt_dp.sv
// datapath: crc, query key, slot memory, probe index and result registers
`timescale 1ns / 1ps
module crchpt_dp import crchpt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               kind,
  input  logic [7:0]         key_byte,
  input  logic               key_last,
  input  logic [31:0]        write_value,
  output logic [31:0]        value,
  output logic               inserted,
  output logic               table_full,
  output logic [SLOT_W-1:0]  slot
);

  typedef struct packed {
    logic                            used;
    logic [LEN_W-1:0]                len;
    logic [31:0]                     val;
    logic [MAX_KEY_LEN-1:0][7:0]     key;
  } row_t;

  row_t                        mem [TABLE_SIZE];
  row_t                        row;
  row_t                        wr_row;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [IDX_W-1:0]            clr_addr;
  logic [31:0]                 crc;
  logic [31:0]                 crc_next;
  logic [MAX_KEY_LEN-1:0][7:0] qkey;
  logic [LEN_W-1:0]            qlen;
  logic                        op_kind;
  logic [31:0]                 op_val;
  logic [IDX_W-1:0]            idx;
  logic [IDX_W-1:0]            cnt;
  logic                        keep;
  logic                        same;
  logic [31:0]                 new_val;

  assign keep     = (qlen < LEN_W'(MAX_KEY_LEN));
  assign crc_next = keep ? crc_feed(crc, key_byte) : crc;

  // key compare over the query length
  always_comb begin
    same = (row.len == qlen);
    for (int i = 0; i < MAX_KEY_LEN; i++) begin
      if ((LEN_W'(i) < qlen) && (row.key[i] != qkey[i])) begin
        same = 1'b0;
      end
    end
  end

  assign sts.clear_done = (clr_addr == IDX_W'(TABLE_SIZE - 1));
  assign sts.empty      = !row.used;
  assign sts.match      = row.used && same;
  assign sts.wrap_end   = (cnt == IDX_W'(TABLE_SIZE - 1));

  assign new_val = (op_kind || row.used) ? (op_kind ? op_val : row.val) : 32'd0;

  // single write port: clearing pass or final update
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_row  = row;
    if (cmd.clear) begin
      wr_en       = 1'b1;
      wr_addr     = clr_addr;
      wr_row.used = 1'b0;
    end else if (cmd.finish && (sts.empty || sts.match)) begin
      wr_en = 1'b1;
      if (sts.empty) begin
        wr_row.used = 1'b1;
        wr_row.len  = qlen;
        wr_row.key  = qkey;
      end
      wr_row.val = new_val;
    end
  end

  // slot memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (cmd.rd) begin
      row <= mem[idx];
    end
  end

  // clear counter, crc and query length
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      crc      <= CRC_INIT;
      qlen     <= '0;
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.take) begin
        crc <= crc_next;
        if (keep) begin
          qlen <= qlen + 1'b1;
        end
      end else if (cmd.finish) begin
        crc  <= CRC_INIT;
        qlen <= '0;
      end
    end
  end

  // key bytes, operation and probe position
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (keep) begin
        qkey[qlen[KEY_IDX_W-1:0]] <= key_byte;
      end
      op_kind <= kind;
      op_val  <= write_value;
      if (key_last) begin
        idx <= IDX_W'(~crc_next);
        cnt <= '0;
      end
    end else if (cmd.next) begin
      idx <= (idx == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx + 1'b1;
      cnt <= cnt + 1'b1;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (sts.empty || sts.match) begin
        value      <= new_val;
        inserted   <= sts.empty;
        table_full <= 1'b0;
        slot       <= SLOT_W'(idx);
      end else begin
        value      <= 32'd0;
        inserted   <= 1'b0;
        table_full <= 1'b1;
        slot       <= '0;
      end
    end
  end

endmodule

FILE: rtl/crchpt_ctrl.sv
// controller: clearing pass, byte intake, probe walk and result handshake
`timescale 1ns / 1ps
module crchpt_ctrl import crchpt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic key_last,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CMP} state_t;

  state_t state;
  logic   out_free;
  logic   done;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign done     = sts.empty || sts.match || sts.wrap_end;

  // command decode
  always_comb begin
    cmd        = '0;
    cmd.clear  = (state == S_CLEAR);
    cmd.take   = (state == S_IDLE) && in_valid;
    cmd.rd     = (state == S_READ);
    cmd.next   = (state == S_CMP) && !done;
    cmd.finish = (state == S_CMP) && done && out_free;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (sts.clear_done) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && key_last) state <= S_READ;
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (!done) begin
            state <= S_READ;
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/crc_hashed_linear_probe_table_core.sv
// top level of the crc-hashed linear probing key/value table
`timescale 1ns / 1ps
// Keys arrive one byte per input item (kind, key_byte, key_last, write_value),
// with key_last marking the final byte; only that final item's kind and
// write_value are used. Bytes past 16 are dropped but key_last still ends the key.
// Each kept byte updates a reflected crc-32. After the final byte the home slot
// is the low 10 bits of the inverted crc and slots are probed in turn,
// wrapping, each by a registered memory read and then a compare.
// One result item (value, inserted, table_full, slot) is given per key, held in
// an output register; the next key's bytes are taken while it waits.
// A full table gives table_full with value, inserted and slot zero.
// After reset a clearing pass marks every slot empty; in_stall stays high
// meanwhile. If out_stall holds a result, a finished probe waits.
module crc_hashed_linear_probe_table_core import crchpt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [7:0]         key_byte,
  input  logic               key_last,
  input  logic [31:0]        write_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        value,
  output logic               inserted,
  output logic               table_full,
  output logic [SLOT_W-1:0]  slot
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  crchpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .key_last  (key_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // storage and compare
  crchpt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .kind        (kind),
    .key_byte    (key_byte),
    .key_last    (key_last),
    .write_value (write_value),
    .value       (value),
    .inserted    (inserted),
    .table_full  (table_full),
    .slot        (slot)
  );

endmodule

FILE: rtl/crchpt_chk.sv
// port-level checker for the hashed table, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crchpt_chk import crchpt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              key_last,
  input logic              out_valid,
  input logic              out_stall,
  input logic [31:0]       value,
  input logic              inserted,
  input logic              table_full,
  input logic [SLOT_W-1:0] slot
);

  // a held result stays
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(value) && $stable(slot))
  // found or placed, never both with full
  `CHK_SAME(a_full_excl, out_valid && table_full, !inserted && (slot == '0) && (value == 32'd0))
  // a taken last byte is followed by in_stall
  `CHK_NEXT(a_probe_busy, in_valid && !in_stall && key_last, in_stall)
  // a fresh result comes out of a busy probe cycle
  `CHK_SAME(a_no_spurious, $rose(out_valid), $past(in_stall))

endmodule

bind crc_hashed_linear_probe_table_core crchpt_chk u_chk (.*);
